### design/assert_macros.svh
// assertion macros shared by the design files
// ASSERT_OFF removes every check; clk and rst_n come from the module that uses a macro
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### design/dmcl_pkg.sv
// shared widths, reset values and register codes of the cache lookup block
// no dependencies
package dmcl_pkg;

    localparam int DMCL_MAX_LINES = 1024;
    localparam int DMCL_ADDR_BITS = 32;

    // item field widths
    localparam int DMCL_ADDRESS_W = 32;
    localparam int DMCL_INDEX_W   = 10;
    localparam int DMCL_TAG_W     = 32;
    localparam int DMCL_COUNT_W   = 32;
    localparam int DMCL_TIME_W    = 48;

    // configuration registers
    localparam int DMCL_CFG_IDX_W = 2;
    localparam int DMCL_CFG_W     = 16;
    localparam int DMCL_LB_W      = 13;
    localparam int DMCL_LC_W      = 11;
    localparam int DMCL_AT_W      = 16;

    localparam logic [DMCL_LB_W-1:0] DMCL_LB_RESET  = 13'd16;
    localparam logic [DMCL_LC_W-1:0] DMCL_LC_RESET  = 11'd64;
    localparam logic [DMCL_AT_W-1:0] DMCL_CAT_RESET = 16'd1;
    localparam logic [DMCL_AT_W-1:0] DMCL_MAT_RESET = 16'd100;

    typedef enum logic [DMCL_CFG_IDX_W-1:0] {
        CFG_LINE_BYTES  = 2'd0,
        CFG_LINE_COUNT  = 2'd1,
        CFG_CACHE_TIME  = 2'd2,
        CFG_MEMORY_TIME = 2'd3
    } cfg_index_t;

endpackage

### design/dmcl_channels.sv
// valid/ready channels: lookup request and lookup result
// depends on dmcl_pkg
interface dmcl_req_if;
    import dmcl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [DMCL_ADDRESS_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface dmcl_rsp_if;
    import dmcl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic [DMCL_INDEX_W-1:0] line_index;
    logic [DMCL_TAG_W-1:0]   line_tag;
    logic                    valid_before;
    logic [DMCL_TAG_W-1:0]   stored_tag_before;
    logic [DMCL_COUNT_W-1:0] hit_total;
    logic [DMCL_COUNT_W-1:0] miss_total;
    logic [DMCL_TIME_W-1:0]  time_total;

    modport source (output valid, output hit, output line_index, output line_tag,
                    output valid_before, output stored_tag_before, output hit_total,
                    output miss_total, output time_total, input ready);
    modport sink   (input valid, input hit, input line_index, input line_tag,
                    input valid_before, input stored_tag_before, input hit_total,
                    input miss_total, input time_total, output ready);
endinterface

### design/direct_mapped_cache_lookup_top.sv
// direct-mapped cache lookup: tag store, valid store, hit/miss counters, time sum
// depends on dmcl_pkg, dmcl_channels, dmcl_divider, assert_macros.svh
//
//  channel | dir | handshake        | payload
//  req     | in  | valid/ready      | address
//  rsp     | out | valid/ready      | hit, line_index, line_tag, valid_before,
//          |     |                  | stored_tag_before, hit_total, miss_total, time_total
//  cfg     | in  | cfg_we, no stall | cfg_index, cfg_data
//
// a result is loaded after its item is accepted and has passed these steps: the shared
// divider runs twice, address by line size and then line number by line count, one bit a
// cycle plus a done step each, then one tag store read and one update step. req is ready
// again the cycle after the update.
// after reset the valid store is cleared one entry a cycle, with req not ready. a result
// waits in the output register; only the update step stalls on it.
module direct_mapped_cache_lookup_top #(
    parameter int MAX_LINES = dmcl_pkg::DMCL_MAX_LINES,
    parameter int ADDR_BITS = dmcl_pkg::DMCL_ADDR_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dmcl_pkg::DMCL_CFG_IDX_W-1:0] cfg_index,
    input  logic [dmcl_pkg::DMCL_CFG_W-1:0]   cfg_data,
    dmcl_req_if.sink                          req,
    dmcl_rsp_if.source                        rsp
);
    import dmcl_pkg::*;
`include "assert_macros.svh"

    localparam int IDX_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LC_W   = ($clog2(MAX_LINES + 1) > DMCL_LC_W) ? $clog2(MAX_LINES + 1)
                                                                 : DMCL_LC_W;
    localparam int DIV_W  = (LC_W > DMCL_LB_W) ? LC_W : DMCL_LB_W;

    typedef enum logic [5:0] {
        ST_CLEAR    = 6'b000001,
        ST_IDLE     = 6'b000010,
        ST_DIV_LINE = 6'b000100,
        ST_DIV_SET  = 6'b001000,
        ST_READ     = 6'b010000,
        ST_CHECK    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [DMCL_LB_W-1:0] line_bytes_reg;
    logic [DMCL_LC_W-1:0] line_count_reg;
    logic [DMCL_AT_W-1:0] cache_time_reg;
    logic [DMCL_AT_W-1:0] memory_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bytes_reg  <= DMCL_LB_RESET;
            line_count_reg  <= DMCL_LC_RESET;
            cache_time_reg  <= DMCL_CAT_RESET;
            memory_time_reg <= DMCL_MAT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_BYTES:  line_bytes_reg  <= cfg_data[DMCL_LB_W-1:0];
                CFG_LINE_COUNT:  line_count_reg  <= cfg_data[DMCL_LC_W-1:0];
                CFG_CACHE_TIME:  cache_time_reg  <= cfg_data[DMCL_AT_W-1:0];
                CFG_MEMORY_TIME: memory_time_reg <= cfg_data[DMCL_AT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry: zero means one, line count capped at the store depth
    logic [DMCL_LB_W-1:0] lb_eff;
    logic [DMCL_LC_W-1:0] lc_nz;
    logic [LC_W-1:0]      lc_ext;
    logic [LC_W-1:0]      lc_eff;

    assign lb_eff = (line_bytes_reg == '0) ? DMCL_LB_W'(1) : line_bytes_reg;
    assign lc_nz  = (line_count_reg == '0) ? DMCL_LC_W'(1) : line_count_reg;
    assign lc_ext = LC_W'(lc_nz);
    assign lc_eff = (lc_ext > LC_W'(MAX_LINES)) ? LC_W'(MAX_LINES) : lc_ext;

    // shared divider
    logic                 div_start;
    logic [ADDR_BITS-1:0] div_dividend;
    logic [DIV_W-1:0]     div_divisor;
    logic                 div_done;
    logic [ADDR_BITS-1:0] div_quot;
    logic [DIV_W-1:0]     div_rem;

    dmcl_divider #(
        .DIVIDEND_W (ADDR_BITS),
        .DIVISOR_W  (DIV_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    logic accept;
    logic slot_free;
    logic update;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_free = !rsp.valid || rsp.ready;
    assign update    = (state_reg == ST_CHECK) && slot_free;

    // first pass: address by line size; second pass: line number by line count
    assign div_start    = accept || ((state_reg == ST_DIV_LINE) && div_done);
    assign div_dividend = accept ? req.address[ADDR_BITS-1:0] : div_quot;
    assign div_divisor  = accept ? DIV_W'(lb_eff) : DIV_W'(lc_eff);

    // lookup context
    logic [IDX_W-1:0]     clr_cnt_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [ADDR_BITS-1:0] tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (state_reg == ST_CLEAR)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DIV_SET) && div_done)
        begin
            idx_reg <= div_rem[IDX_W-1:0];
            tag_reg <= div_quot;
        end
    end

    // valid store and tag store
    logic                 valid_mem [MAX_LINES];
    logic [ADDR_BITS-1:0] tag_mem   [MAX_LINES];
    logic                 vrd_reg;
    logic [ADDR_BITS-1:0] trd_reg;
    logic                 hit;
    logic                 v_we;
    logic [IDX_W-1:0]     v_waddr;

    assign hit     = vrd_reg && (trd_reg == tag_reg);
    assign v_we    = (state_reg == ST_CLEAR) || (update && !hit);
    assign v_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : idx_reg;

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            valid_mem[v_waddr] <= (state_reg != ST_CLEAR);
        end
        vrd_reg <= valid_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (update && !hit)
        begin
            tag_mem[idx_reg] <= tag_reg;
        end
        trd_reg <= tag_mem[idx_reg];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(MAX_LINES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV_LINE;
                end
            end
            ST_DIV_LINE:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV_SET;
                end
            end
            ST_DIV_SET:
            begin
                if (div_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // counters and time sum, saturating
    logic [DMCL_COUNT_W-1:0] hit_cnt_reg,  hit_cnt_next;
    logic [DMCL_COUNT_W-1:0] miss_cnt_reg, miss_cnt_next;
    logic [DMCL_TIME_W-1:0]  time_reg,     time_next;
    logic [DMCL_TIME_W:0]    time_sum;

    assign time_sum = {1'b0, time_reg}
                    + (DMCL_TIME_W + 1)'(hit ? cache_time_reg : memory_time_reg);

    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (hit)
        begin
            if (hit_cnt_reg != '1)
            begin
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end
        end
        else if (miss_cnt_reg != '1)
        begin
            miss_cnt_next = miss_cnt_reg + 1'b1;
        end
        time_next = time_sum[DMCL_TIME_W] ? '1 : time_sum[DMCL_TIME_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            time_reg     <= '0;
        end
        else if (update)
        begin
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            time_reg     <= time_next;
        end
    end

    // result register
    logic                    out_valid_reg;
    logic                    out_hit_reg;
    logic [DMCL_INDEX_W-1:0] out_index_reg;
    logic [DMCL_TAG_W-1:0]   out_tag_reg;
    logic                    out_vbefore_reg;
    logic [DMCL_TAG_W-1:0]   out_stag_reg;
    logic [DMCL_COUNT_W-1:0] out_hits_reg;
    logic [DMCL_COUNT_W-1:0] out_misses_reg;
    logic [DMCL_TIME_W-1:0]  out_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            out_hit_reg     <= hit;
            out_index_reg   <= DMCL_INDEX_W'(idx_reg);
            out_tag_reg     <= DMCL_TAG_W'(tag_reg);
            out_vbefore_reg <= vrd_reg;
            // an entry never filled reads as zero
            out_stag_reg    <= vrd_reg ? DMCL_TAG_W'(trd_reg) : '0;
            out_hits_reg    <= hit_cnt_next;
            out_misses_reg  <= miss_cnt_next;
            out_time_reg    <= time_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.hit               = out_hit_reg;
    assign rsp.line_index        = out_index_reg;
    assign rsp.line_tag          = out_tag_reg;
    assign rsp.valid_before      = out_vbefore_reg;
    assign rsp.stored_tag_before = out_stag_reg;
    assign rsp.hit_total         = out_hits_reg;
    assign rsp.miss_total        = out_misses_reg;
    assign rsp.time_total        = out_time_reg;

    `ASSERT_RST(a_hit_matches_tag,
        (rsp.valid && rsp.hit) |-> (rsp.valid_before && rsp.stored_tag_before == rsp.line_tag),
        "hit reported without a matching valid entry")
    `ASSERT_ALWAYS(a_invalid_tag_zero,
        (rsp.valid && !rsp.valid_before) |-> (rsp.stored_tag_before == '0),
        "stored tag shown for an invalid entry")
    `ASSERT_RST(a_div_done_in_pass,
        div_done |-> (state_reg == ST_DIV_LINE || state_reg == ST_DIV_SET),
        "divider finished outside a division pass")
    `ASSERT_RST(a_result_counts,
        $rose(out_valid_reg) |-> (rsp.hit_total != '0 || rsp.miss_total != '0),
        "result delivered with both counters at zero")
endmodule

### design/dmcl_divider.sv
// iterative restoring divider, one quotient bit per cycle
// standalone; started by the lookup sequencer
module dmcl_divider #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);
    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVISOR_W+1:0]  diff;
    logic                  fits;

    // partial remainder shifted left by one with the next dividend bit
    assign diff = {1'b0, rem_reg, quot_reg[DIVIDEND_W-1]} - {2'b00, div_reg};
    assign fits = ~diff[DIVISOR_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DIVIDEND_W-2:0], fits};
            rem_reg  <= fits ? diff[DIVISOR_W-1:0]
                             : {rem_reg[DIVISOR_W-2:0], quot_reg[DIVIDEND_W-1]};
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;
endmodule
